// File: rtl/park_pkg.sv
// ----------------------------------------------------------------------------
// park_pkg: shared types and constants for the Park rotator
// Default widths, quadrant codes and the quarter-wave sine entry generator
// that fills the rotator's sine ROM at elaboration.
// ----------------------------------------------------------------------------
package park_pkg;

	// Default field widths
	localparam int unsigned DATA_BITS_DEF  = 16;
	localparam int unsigned ANGLE_BITS_DEF = 16;
	localparam int unsigned TABLE_BITS_DEF = 10;

	// pi/2 in unsigned Q30
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] Q30_ONE     = 64'd1 << 30;

	// Quadrant selected by the top two angle bits
	typedef enum logic [1:0] {
		QUAD_FIRST  = 2'd0,
		QUAD_SECOND = 2'd1,
		QUAD_THIRD  = 2'd2,
		QUAD_FOURTH = 2'd3
	} quad_t;

	// Entry k of the quarter-wave table: sin(pi/2 * k / 2^table_bits) in
	// Q1.(data_bits-1), evaluated by a truncated Taylor series in Q30,
	// rounded half up and clamped to the positive full scale.
	function automatic logic [63:0] sine_entry(input int unsigned k,
		input int unsigned data_bits, input int unsigned table_bits);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] v;
		logic [63:0] maxv;
		x    = (HALF_PI_Q30 * 64'(k) + ((64'd1 << table_bits) >> 1)) >> table_bits;
		x2   = (x * x + (Q30_ONE >> 1)) >> 30;
		t    = Q30_ONE;
		t    = Q30_ONE - ((x2 * t) >> 30) / 64'd210;
		t    = Q30_ONE - ((x2 * t) >> 30) / 64'd156;
		t    = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
		t    = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
		t    = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
		t    = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
		t    = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
		s    = (x * t) >> 30;
		v    = (s * (64'd1 << (data_bits - 1)) + (Q30_ONE >> 1)) >> 30;
		maxv = (64'd1 << (data_bits - 1)) - 64'd1;
		if (v > maxv) begin
			v = maxv;
		end
		return v;
	endfunction

endpackage

// File: rtl/park_transform.sv
// ----------------------------------------------------------------------------
// park_transform: forward Park rotation, alpha/beta to d/q
// Six-stage pipeline: angle decode, sine ROM read, quadrant mapping,
// products, rounded sums, saturation into the output register.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one transfer carries alpha, beta and the rotor angle.
//   Output stream (m_*): one transfer carries d and q for each input transfer,
//   in the same order.
//   d =  alpha*cos + beta*sin,  q = beta*cos - alpha*sin, rounded half up to
//   Q1.(DATA_BITS-1) and saturated to the signed DATA_BITS range.
// Throughput: one transfer per cycle while the output is not stalled; every
//   stage holds one item and stage 2 reads both sine ROM entries at once.
// Stall: when m_tvalid is high and m_tready low, the whole pipeline holds and
//   s_tready drops; nothing is dropped or repeated.
// Reset: arst_n clears all stage valid bits; the output goes idle at once.
//   The sine ROM is constant and needs no fill after reset.
// ----------------------------------------------------------------------------
module park_transform #(
	parameter int unsigned DATA_BITS  = park_pkg::DATA_BITS_DEF,
	parameter int unsigned ANGLE_BITS = park_pkg::ANGLE_BITS_DEF,
	parameter int unsigned TABLE_BITS = park_pkg::TABLE_BITS_DEF,
	localparam int unsigned IN_W  = ((2 * DATA_BITS + ANGLE_BITS + 7) / 8) * 8,
	localparam int unsigned OUT_W = ((2 * DATA_BITS + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // alpha_in, beta_in, rotor_angle
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata    // d_axis, q_axis
);

	localparam int unsigned TBL_DEPTH = (1 << TABLE_BITS) + 1;
	localparam int unsigned SUM_W     = 2 * DATA_BITS + 1;
	localparam logic [SUM_W-1:0] RND_HALF =
		{{(DATA_BITS + 2){1'b0}}, 1'b1, {(DATA_BITS - 2){1'b0}}};

	// Stage valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic adv;

	// Input unpack
	logic signed [DATA_BITS-1:0] alpha_in;
	logic signed [DATA_BITS-1:0] beta_in;
	logic [ANGLE_BITS-1:0]       rotor_angle;
	logic [TABLE_BITS-1:0]       phase;

	// Stage registers
	logic signed [DATA_BITS-1:0] a_s1, a_s2, a_s3;
	logic signed [DATA_BITS-1:0] b_s1, b_s2, b_s3;
	park_pkg::quad_t             quad_s1, quad_s2;
	logic [TABLE_BITS-1:0]       p_s1;
	logic [TABLE_BITS:0]         np_s1;
	logic [DATA_BITS-2:0]        tp_s2, tq_s2;
	logic signed [DATA_BITS-1:0] sn_s3, cs_s3;
	logic signed [DATA_BITS-1:0] sn_c, cs_c;
	logic signed [2*DATA_BITS-1:0] ac_s4, bs_s4, bc_s4, as_s4;
	logic signed [SUM_W-1:0]     d_sum_s5, q_sum_s5;
	logic signed [DATA_BITS+1:0] d_sh, q_sh;
	logic signed [DATA_BITS-1:0] d_sat, q_sat;
	logic signed [DATA_BITS-1:0] d_axis_s6, q_axis_s6;

	// Quarter-wave sine ROM
	logic [DATA_BITS-2:0] sine_rom [TBL_DEPTH];

	genvar gk;
	generate
		for (gk = 0; gk < TBL_DEPTH; gk++) begin : g_rom
			assign sine_rom[gk] = (DATA_BITS - 1)'(park_pkg::sine_entry(gk, DATA_BITS,
				TABLE_BITS));
		end
	endgenerate

	// Advance all stages unless the output holds a result not yet taken
	assign adv      = !v_s6 || m_tready;
	assign s_tready = adv;

	assign alpha_in    = $signed(s_tdata[DATA_BITS-1:0]);
	assign beta_in     = $signed(s_tdata[2*DATA_BITS-1:DATA_BITS]);
	assign rotor_angle = s_tdata[2*DATA_BITS+ANGLE_BITS-1:2*DATA_BITS];

	// Phase: angle bits below the quadrant, aligned to the table index width
	generate
		if (ANGLE_BITS - 2 >= TABLE_BITS) begin : g_phase_trunc
			assign phase = rotor_angle[ANGLE_BITS-3 -: TABLE_BITS];
		end else begin : g_phase_fill
			assign phase = {rotor_angle[ANGLE_BITS-3:0],
				{(TABLE_BITS - ANGLE_BITS + 2){1'b0}}};
		end
	endgenerate

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Stage 1: decode quadrant and both table addresses
	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1    <= alpha_in;
			b_s1    <= beta_in;
			quad_s1 <= park_pkg::quad_t'(rotor_angle[ANGLE_BITS-1 -: 2]);
			p_s1    <= phase;
			np_s1   <= {1'b1, {TABLE_BITS{1'b0}}} - {1'b0, phase};
		end
	end

	// Stage 2: read sine at p and at N-p
	always_ff @(posedge clk) begin
		if (adv) begin
			a_s2    <= a_s1;
			b_s2    <= b_s1;
			quad_s2 <= quad_s1;
			tp_s2   <= sine_rom[{1'b0, p_s1}];
			tq_s2   <= sine_rom[np_s1];
		end
	end

	// Stage 3: map table values to signed sine and cosine
	always_comb begin
		unique case (quad_s2)
			park_pkg::QUAD_FIRST: begin
				sn_c = $signed({1'b0, tp_s2});
				cs_c = $signed({1'b0, tq_s2});
			end
			park_pkg::QUAD_SECOND: begin
				sn_c = $signed({1'b0, tq_s2});
				cs_c = -$signed({1'b0, tp_s2});
			end
			park_pkg::QUAD_THIRD: begin
				sn_c = -$signed({1'b0, tp_s2});
				cs_c = -$signed({1'b0, tq_s2});
			end
			park_pkg::QUAD_FOURTH: begin
				sn_c = -$signed({1'b0, tq_s2});
				cs_c = $signed({1'b0, tp_s2});
			end
			default: begin
				sn_c = '0;
				cs_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s3  <= a_s2;
			b_s3  <= b_s2;
			sn_s3 <= sn_c;
			cs_s3 <= cs_c;
		end
	end

	// Stage 4: four full-precision products
	always_ff @(posedge clk) begin
		if (adv) begin
			ac_s4 <= a_s3 * cs_s3;
			bs_s4 <= b_s3 * sn_s3;
			bc_s4 <= b_s3 * cs_s3;
			as_s4 <= a_s3 * sn_s3;
		end
	end

	// Stage 5: exact sums plus the rounding half
	always_ff @(posedge clk) begin
		if (adv) begin
			d_sum_s5 <= SUM_W'(ac_s4) + SUM_W'(bs_s4) + $signed(RND_HALF);
			q_sum_s5 <= SUM_W'(bc_s4) - SUM_W'(as_s4) + $signed(RND_HALF);
		end
	end

	// Stage 6: floor shift and clamp to the signed data range
	assign d_sh = $signed(d_sum_s5[SUM_W-1:DATA_BITS-1]);
	assign q_sh = $signed(q_sum_s5[SUM_W-1:DATA_BITS-1]);

	always_comb begin
		if (d_sh[DATA_BITS+1:DATA_BITS-1] == 3'b000 ||
				d_sh[DATA_BITS+1:DATA_BITS-1] == 3'b111) begin
			d_sat = d_sh[DATA_BITS-1:0];
		end else if (d_sh[DATA_BITS+1]) begin
			d_sat = {1'b1, {(DATA_BITS - 1){1'b0}}};
		end else begin
			d_sat = {1'b0, {(DATA_BITS - 1){1'b1}}};
		end
		if (q_sh[DATA_BITS+1:DATA_BITS-1] == 3'b000 ||
				q_sh[DATA_BITS+1:DATA_BITS-1] == 3'b111) begin
			q_sat = q_sh[DATA_BITS-1:0];
		end else if (q_sh[DATA_BITS+1]) begin
			q_sat = {1'b1, {(DATA_BITS - 1){1'b0}}};
		end else begin
			q_sat = {1'b0, {(DATA_BITS - 1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_axis_s6 <= d_sat;
			q_axis_s6 <= q_sat;
		end
	end

	// Output register drives the master side
	assign m_tvalid = v_s6;
	assign m_tdata  = OUT_W'({q_axis_s6, d_axis_s6});

endmodule

// File: test/park_transform_test.sv
// ----------------------------------------------------------------------------
// park_transform_test: self-checking bench for the Park rotator
// Drives alpha/beta/angle transfers into the rotator and checks every d/q
// transfer against a bit-true rotation model kept in a small scoreboard.
// Both stream sides idle in random bursts; one long output hold-off fills
// the pipeline, and the sender drains the block between phases.
// ----------------------------------------------------------------------------
module park_transform_test;

	localparam int unsigned DW = park_pkg::DATA_BITS_DEF;
	localparam int unsigned AW = park_pkg::ANGLE_BITS_DEF;
	localparam int unsigned TW = park_pkg::TABLE_BITS_DEF;
	localparam int unsigned TN = 1 << TW;
	localparam int unsigned IN_W  = ((2 * DW + AW + 7) / 8) * 8;
	localparam int unsigned OUT_W = ((2 * DW + 7) / 8) * 8;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned TAIL_CYCLES = 12;

	typedef struct packed {
		logic signed [DW-1:0] q;
		logic signed [DW-1:0] d;
	} dq_t;

	// Scoreboard: quarter-wave sine model, rotation predictor, pending d/q
	class dq_scoreboard;
		longint sine_rom[TN+1];
		dq_t dq_due[$];
		int unsigned mismatches;

		function new();
			mismatches = 0;
			for (int k = 0; k <= TN; k++) begin
				sine_rom[k] = sine_q15(k);
			end
		endfunction

		// Evaluate sin(pi/2 * k/N) by the truncated Q30 series
		function longint sine_q15(input int k);
			longint unsigned one;
			longint unsigned x;
			longint unsigned x2;
			longint unsigned t;
			longint unsigned s;
			longint unsigned v;
			longint unsigned top;
			longint unsigned divs[7];
			one  = 64'd1 << 30;
			divs = '{64'd210, 64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
			x    = (64'd1686629713 * 64'(k) + (64'(TN) >> 1)) >> TW;
			x2   = (x * x + (one >> 1)) >> 30;
			t    = one;
			for (int i = 0; i < 7; i++) begin
				t = one - ((x2 * t) >> 30) / divs[i];
			end
			s   = (x * t) >> 30;
			v   = (s * (64'd1 << (DW - 1)) + (one >> 1)) >> 30;
			top = (64'd1 << (DW - 1)) - 64'd1;
			if (v > top) begin
				v = top;
			end
			return longint'(v);
		endfunction

		// Round half up to Q1.15 and clamp to the signed range
		function logic [DW-1:0] round_clamp(input longint acc);
			longint r;
			longint lim;
			lim = longint'(1) << (DW - 1);
			r   = (acc + (longint'(1) << (DW - 2))) >>> (DW - 1);
			if (r > lim - 1) begin
				r = lim - 1;
			end
			if (r < -lim) begin
				r = -lim;
			end
			return r[DW-1:0];
		endfunction

		function dq_t rotate_dq(input logic signed [DW-1:0] a,
			input logic signed [DW-1:0] b, input logic [AW-1:0] ang);
			park_pkg::quad_t quad;
			int p;
			longint tp;
			longint tq;
			longint sn;
			longint cs;
			dq_t r;
			quad = park_pkg::quad_t'(ang[AW-1 -: 2]);
			p    = int'(ang[AW-3 -: TW]);
			tp   = sine_rom[p];
			tq   = sine_rom[TN - p];
			case (quad)
				park_pkg::QUAD_FIRST: begin
					sn = tp;
					cs = tq;
				end
				park_pkg::QUAD_SECOND: begin
					sn = tq;
					cs = -tp;
				end
				park_pkg::QUAD_THIRD: begin
					sn = -tp;
					cs = -tq;
				end
				default: begin
					sn = -tq;
					cs = tp;
				end
			endcase
			r.d = round_clamp(longint'(a) * cs + longint'(b) * sn);
			r.q = round_clamp(longint'(b) * cs - longint'(a) * sn);
			return r;
		endfunction

		// Queue the expected rotation of an accepted input transfer
		function void note_sample(input logic [IN_W-1:0] data);
			dq_due.push_back(rotate_dq(data[DW-1:0], data[2*DW-1:DW],
				data[2*DW+AW-1:2*DW]));
		endfunction

		// Compare an output transfer with the oldest pending rotation
		function void check_dq(input logic [OUT_W-1:0] data);
			dq_t got;
			dq_t want;
			got = data[2*DW-1:0];
			if (dq_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual d=%0d q=%0d",
					$time, got.d, got.q);
				mismatches++;
				return;
			end
			want = dq_due.pop_front();
			if (got.d !== want.d) begin
				$display("%0t: d_axis mismatch, expected %0d, actual %0d",
					$time, want.d, got.d);
				mismatches++;
			end
			if (got.q !== want.q) begin
				$display("%0t: q_axis mismatch, expected %0d, actual %0d",
					$time, want.q, got.q);
				mismatches++;
			end
		endfunction

		function int pending();
			return dq_due.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	dq_scoreboard sb;
	bit idle_on = 1'b1;
	bit hold_req = 1'b0;
	int unsigned quiet_cycles = 0;

	park_transform i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Record input transfers and check output transfers
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				sb.note_sample(s_tdata);
			end
			if (m_tvalid && m_tready) begin
				sb.check_dq(m_tdata);
			end
		end
	end

	// End the run when no transfer happens for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Receiver: random stall bursts, plus one long hold-off on request
	initial begin
		int stall_left;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req   = 1'b0;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				stall_left = $urandom_range(1, 19) - 1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Offer one transfer, with an optional idle burst ahead of it
	task automatic send_item(input logic [DW-1:0] a, input logic [DW-1:0] b,
		input logic [AW-1:0] ang);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_W'({ang, b, a});
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// Stop offering and wait for every pending result
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// Component value weighted toward the full-scale corners
	function automatic logic [DW-1:0] pick_comp();
		case ($urandom_range(0, 11))
			0: return {1'b0, {(DW-1){1'b1}}};
			1: return {1'b1, {(DW-1){1'b0}}};
			2: return '0;
			3: return '1;
			default: return DW'($urandom);
		endcase
	endfunction

	// Angle mostly uniform, sometimes on a quadrant or table boundary
	function automatic logic [AW-1:0] pick_angle();
		case ($urandom_range(0, 9))
			0: return {2'($urandom_range(0, 3)), {(AW-2){1'b0}}};
			1: return {2'($urandom_range(0, 3)), {(AW-2){1'b1}}};
			default: return AW'($urandom);
		endcase
	endfunction

	task automatic send_random(input int n);
		for (int i = 0; i < n; i++) begin
			send_item(pick_comp(), pick_comp(), pick_angle());
		end
	endtask

	initial begin
		sb = new();
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: zero, full-scale axes, quadrant edges, dropped angle bits
		send_item(16'h0000, 16'h0000, 16'h0000);
		send_item(16'h7FFF, 16'h0000, 16'h0000);
		send_item(16'h8000, 16'h0000, 16'h0000);
		send_item(16'h0000, 16'h7FFF, 16'h0000);
		send_item(16'h0000, 16'h8000, 16'h0000);
		send_item(16'h7FFF, 16'h1234, 16'h4000);
		send_item(16'h7FFF, 16'h1234, 16'h8000);
		send_item(16'h7FFF, 16'h1234, 16'hC000);
		send_item(16'h7FFF, 16'h8000, 16'hFFFF);
		send_item(16'h4000, 16'hC000, 16'h000F);
		send_item(16'h4000, 16'hC000, 16'h0010);
		send_item(16'h4000, 16'hC000, 16'h3FFF);
		send_item(16'hFFFF, 16'h0001, 16'h2000);
		// Saturation: rotated full-scale vectors exceed the Q1.15 range
		send_item(16'h7FFF, 16'h7FFF, 16'h2000);
		send_item(16'h8000, 16'h8000, 16'h2000);
		send_item(16'h8000, 16'h7FFF, 16'h2000);
		send_item(16'h7FFF, 16'h8000, 16'h2000);
		send_item(16'h8000, 16'h8000, 16'hA000);
		send_item(16'h8000, 16'h8000, 16'h0000);
		send_item(16'h5A82, 16'hA57E, 16'h6000);
		wait_drained();

		// Random traffic with idling on both sides
		send_random(500);

		// Hold the output while the sender keeps offering back to back
		idle_on  = 1'b0;
		hold_req = 1'b1;
		send_random(60);
		idle_on  = 1'b1;
		send_random(500);
		wait_drained();

		// Final stretch at full rate
		idle_on = 1'b0;
		send_random(440);
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
